@@ hdl/srpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted ring priority queue package
// Request and result formats, status and mode codes, default depth.
// ----------------------------------------------------------------------------
package srpq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
    } srpq_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [5:0]         occupancy;
    } srpq_out_t;

endpackage

@@ hdl/sorted_ring_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted ring priority queue
// Bounded priority queue kept as a sorted circular buffer in one RAM, served
// by a sequencer that reads one entry per cycle through a registered port.
// Paths: a refused request goes straight to its result; remove reads the head;
//   insert into an empty queue writes the key at once; append at tail checks
//   the tail entry; ordered insert searches, shifts later entries up, writes the key.
// Requests: one at a time; the next is taken once the result has moved into
//   the output register. The search and shift step through the RAM one
//   entry per cycle.
// Reset: synchronous, active low; clears count, head and order bit. RAM is not
//   cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue
    import srpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  srpq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output srpq_out_t m_data
);

    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TAIL   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_PLACE  = 7'b0010000,
        S_REMOVE = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               desc_reg;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic signed [31:0] key_reg, key_next;
    srpq_out_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    srpq_out_t          m_data_reg, m_data_next;

    logic signed [31:0] mem [QUEUE_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;

    logic               out_free;
    logic               ahead;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0]  pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(pos);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return SLOT_W'(s);
    endfunction

    // entry read last cycle stays ahead of the key being inserted
    assign ahead = desc_reg ? (rd_data_reg >= key_reg) : (rd_data_reg <= key_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_addr      = head_reg;
        wr_en        = 1'b0;
        wr_addr      = slot_of(head_reg, pos_reg);
        wr_data      = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.value;
                    res_next = '{status: ST_OK, removed_value: '0,
                                 occupancy: 6'(count_reg)};
                    if (s_data.mode == MODE_REMOVE) begin
                        if (count_reg == '0) begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            rd_addr    = head_reg;
                            state_next = S_REMOVE;
                        end
                    end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end else if (count_reg == '0) begin
                        pos_next   = '0;
                        state_next = S_PLACE;
                    end else begin
                        rd_addr    = slot_of(head_reg, count_reg - 1'b1);
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (ahead) begin
                    pos_next   = count_reg;
                    state_next = S_PLACE;
                end else begin
                    ptr_next   = '0;
                    rd_addr    = head_reg;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // tail already failed the test, so the scan stops at the tail at the latest
                if (ahead) begin
                    ptr_next = ptr_reg + 1'b1;
                    rd_addr  = slot_of(head_reg, ptr_reg + 1'b1);
                end else begin
                    pos_next   = ptr_reg;
                    ptr_next   = count_reg;
                    rd_addr    = slot_of(head_reg, count_reg - 1'b1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move entry ptr-1 up to ptr, then fetch the next one down
                wr_en    = 1'b1;
                wr_addr  = slot_of(head_reg, ptr_reg);
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg - 1'b1;
                if (ptr_reg - 1'b1 == pos_reg) begin
                    state_next = S_PLACE;
                end else begin
                    rd_addr = slot_of(head_reg, ptr_reg - CNT_W'(2));
                end
            end
            S_PLACE: begin
                wr_en              = 1'b1;
                wr_addr            = slot_of(head_reg, pos_reg);
                wr_data            = key_reg;
                count_next         = count_reg + 1'b1;
                res_next.occupancy = 6'(count_reg + 1'b1);
                state_next         = S_DONE;
            end
            S_REMOVE: begin
                res_next.removed_value = rd_data_reg;
                res_next.occupancy     = 6'(count_reg - 1'b1);
                count_next             = count_reg - 1'b1;
                head_next              = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + 1'b1;
                state_next             = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            desc_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_shift_above_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (ptr_reg > pos_reg))
        else $error("shift pointer at or below insert position");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg.status == ST_FULL)
            |-> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with free entries");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");
`endif

endmodule
